// ----- hdl/minimum_spanning_tree_engine_macros.svh -----
// Assertion macros for the minimum spanning tree engine
`ifndef MINIMUM_SPANNING_TREE_ENGINE_MACROS_SVH
`define MINIMUM_SPANNING_TREE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define MST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MST_ASSERT(lbl, clk, rst, prop, msg)
`define MST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/mst_pkg.sv -----
// Shared constants and controller/datapath types for the spanning tree engine
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam int VID_W    = 6;
   localparam int WGT_W    = 16;
   localparam int ACC_W    = 24;
   localparam int VC_W     = 7;
   localparam int RANK_W   = 3;
   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
   localparam logic [VC_W-1:0]   VC_RESET = 7'd64;

   typedef struct packed {
      logic load;
      logic init;
      logic scan_start;
      logic scan_step;
      logic take_best;
      logic find_start;
      logic sel_b;
      logic uf_read;
      logic find_step;
      logic comp_start;
      logic comp_step;
      logic save_root;
      logic join_write;
      logic join_bump;
      logic emit_edge;
      logic emit_summary;
   } cmd_type;

   typedef struct packed {
      logic tree_full;
      logic scan_done;
      logic best_found;
      logic at_root;
      logic comp_done;
      logic same_root;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

// ----- hdl/mst_channels.sv -----
// Request, response and register-write channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface mst_req_if;
   import mst_pkg::*;
   logic             valid;
   logic             ready;
   logic [VID_W-1:0] edge_from;
   logic [VID_W-1:0] edge_to;
   logic [WGT_W-1:0] edge_weight;
   logic             last_edge;
   modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
   modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface mst_rsp_if;
   import mst_pkg::*;
   logic             valid;
   logic             ready;
   logic [VID_W-1:0] tree_from;
   logic [VID_W-1:0] tree_to;
   logic [WGT_W-1:0] tree_edge_weight;
   logic             is_summary;
   logic [ACC_W-1:0] graph_weight;
   logic [ACC_W-1:0] spanning_weight;
   logic [ACC_W-1:0] saved_weight;
   logic             last_result;
   modport source (output valid, tree_from, tree_to, tree_edge_weight, is_summary,
                   graph_weight, spanning_weight, saved_weight, last_result, input ready);
   modport sink   (input valid, tree_from, tree_to, tree_edge_weight, is_summary,
                   graph_weight, spanning_weight, saved_weight, last_result, output ready);
endinterface

interface mst_csr_if;
   import mst_pkg::*;
   logic            valid;
   logic            ready;
   logic [VC_W-1:0] vertex_count;
   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

// ----- hdl/minimum_spanning_tree_engine.sv -----
// Top level of the Kruskal spanning tree engine
//
//  channel  dir  handshake    transaction
//  req      in   valid/ready  one weighted edge, last_edge starts the run
//  rsp      out  valid/ready  one tree edge, or the closing summary
//  csr      in   valid/ready  vertex_count write (always ready)
//
// Loading takes one edge per cycle. After the last edge the engine scans the
// single-port edge store once per candidate edge (with start and pick states)
// and walks the union-find memory with a read and a check or write state per
// step of find and compression. No edge is taken while a graph is processed.
// Reset is synchronous; the union-find is reset through per-entry valid bits.
// A result waiting on rsp stalls the engine only at its next emit.
`timescale 1ns / 1ps
`default_nettype none
module minimum_spanning_tree_engine import mst_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   mst_req_if.sink   req,
   mst_rsp_if.source rsp,
   mst_csr_if.sink   csr
);
   cmd_type cmd;
   sts_type sts;

   assign csr.ready = 1'b1;

   mst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_edge),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mst_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_from   (req.edge_from),
      .in_to     (req.edge_to),
      .in_weight (req.edge_weight),
      .csr_wr    (csr.valid),
      .csr_data  (csr.vertex_count),
      .rsp       (rsp)
   );
endmodule
`default_nettype wire

// ----- hdl/mst_datapath.sv -----
// Datapath: edge store, ordered scan, union-find memory, sums and result register
`timescale 1ns / 1ps
`default_nettype none
`include "minimum_spanning_tree_engine_macros.svh"
module mst_datapath import mst_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output sts_type               sts,
   input  wire logic [VID_W-1:0] in_from,
   input  wire logic [VID_W-1:0] in_to,
   input  wire logic [WGT_W-1:0] in_weight,
   input  wire logic             csr_wr,
   input  wire logic [VC_W-1:0]  csr_data,
   mst_rsp_if.source             rsp
);
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int FW = $clog2(MAX_EDGES + 1);
   localparam int VW = $clog2(MAX_VERTICES);
   localparam logic [WGT_W-1:0] WMASK =
      (WEIGHT_BITS >= WGT_W) ? {WGT_W{1'b1}} : WGT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
   localparam logic [FW-1:0] FILL_MAX = FW'(MAX_EDGES);
   localparam logic [VC_W-1:0] VC_MAX = VC_W'(MAX_VERTICES);

   // edge store
   logic [VID_W-1:0] ef_mem [MAX_EDGES];
   logic [VID_W-1:0] et_mem [MAX_EDGES];
   logic [WGT_W-1:0] ew_mem [MAX_EDGES];

   logic [FW-1:0]    fill_ff;
   logic [ACC_W-1:0] total_ff;
   logic [ACC_W-1:0] tree_ff;
   logic [VC_W-1:0]  count_ff;
   logic [VC_W-1:0]  vc_ff;
   logic [VC_W-1:0]  vc_eff;

   // scan
   logic [FW-1:0]    rd_idx_ff;
   logic             eval_ff;
   logic [AW-1:0]    idx_q_ff;
   logic [VID_W-1:0] qf_ff, qt_ff;
   logic [WGT_W-1:0] qw_ff;
   logic             first_ff;
   logic [WGT_W-1:0] last_w_ff;
   logic [AW-1:0]    last_i_ff;
   logic             best_ff;
   logic [VID_W-1:0] bf_ff, bt_ff;
   logic [WGT_W-1:0] bw_ff;
   logic [AW-1:0]    bi_ff;
   logic             in_range, after_last, better;

   // union-find
   logic [VW-1:0]     par_mem  [MAX_VERTICES];
   logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] uf_valid_ff;
   logic [VW-1:0]     par_q_ff;
   logic [RANK_W-1:0] rank_q_ff;
   logic              vq_ff;
   logic [VW-1:0]     uf_par;
   logic [RANK_W-1:0] uf_rank;
   logic [VW-1:0]     cur_ff, orig_ff, root_ff;
   logic [RANK_W-1:0] root_rank_ff;
   logic [VW-1:0]     ra_ff, rb_ff;
   logic [RANK_W-1:0] rka_ff, rkb_ff;
   logic              uf_we;
   logic [VW-1:0]     uf_waddr, uf_wpar;
   logic [RANK_W-1:0] uf_wrank;

   logic rsp_valid_ff;
   logic [WGT_W-1:0] w_in;

   assign w_in   = in_weight & WMASK;
   assign vc_eff = (vc_ff > VC_MAX) ? VC_MAX : vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff    <= VC_RESET;
         fill_ff  <= '0;
         total_ff <= '0;
         tree_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_wr) vc_ff <= csr_data;
         if (cmd.load) begin
            total_ff <= total_ff + ACC_W'(w_in);
            if (fill_ff < FILL_MAX) fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.init) begin
            tree_ff  <= '0;
            count_ff <= '0;
         end
         if (cmd.emit_edge) begin
            tree_ff  <= tree_ff + ACC_W'(bw_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.emit_summary) begin
            fill_ff  <= '0;
            total_ff <= '0;
            tree_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && fill_ff < FILL_MAX) begin
         ef_mem[fill_ff[AW-1:0]] <= in_from;
         et_mem[fill_ff[AW-1:0]] <= in_to;
         ew_mem[fill_ff[AW-1:0]] <= w_in;
      end
      if (cmd.scan_step && rd_idx_ff < fill_ff) begin
         qf_ff    <= ef_mem[rd_idx_ff[AW-1:0]];
         qt_ff    <= et_mem[rd_idx_ff[AW-1:0]];
         qw_ff    <= ew_mem[rd_idx_ff[AW-1:0]];
         idx_q_ff <= rd_idx_ff[AW-1:0];
      end
   end

   assign in_range   = (VC_W'(qf_ff) < vc_eff) && (VC_W'(qt_ff) < vc_eff) && (qf_ff != qt_ff);
   assign after_last = first_ff || (qw_ff > last_w_ff) ||
                       ((qw_ff == last_w_ff) && (idx_q_ff > last_i_ff));
   assign better     = !best_ff || (qw_ff < bw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         eval_ff   <= 1'b0;
         best_ff   <= 1'b0;
         first_ff  <= 1'b1;
      end else begin
         if (cmd.init) first_ff <= 1'b1;
         if (cmd.scan_start) begin
            rd_idx_ff <= '0;
            eval_ff   <= 1'b0;
            best_ff   <= 1'b0;
         end else if (cmd.scan_step) begin
            if (rd_idx_ff < fill_ff) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
               eval_ff   <= 1'b1;
            end else begin
               eval_ff <= 1'b0;
            end
            if (eval_ff && in_range && after_last && better) best_ff <= 1'b1;
         end
         if (cmd.take_best) first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && eval_ff && in_range && after_last && better) begin
         bf_ff <= qf_ff;
         bt_ff <= qt_ff;
         bw_ff <= qw_ff;
         bi_ff <= idx_q_ff;
      end
      if (cmd.take_best) begin
         last_w_ff <= bw_ff;
         last_i_ff <= bi_ff;
      end
   end

   // union-find memory, entries without a valid bit read as their own root of rank zero
   assign uf_par  = vq_ff ? par_q_ff  : cur_ff;
   assign uf_rank = vq_ff ? rank_q_ff : '0;

   always_comb begin
      uf_we    = 1'b0;
      uf_waddr = cur_ff;
      uf_wpar  = root_ff;
      uf_wrank = uf_rank;
      if (cmd.comp_step) begin
         uf_we = 1'b1;
      end else if (cmd.join_write) begin
         uf_we = 1'b1;
         if (rka_ff > rkb_ff) begin
            uf_waddr = rb_ff;
            uf_wpar  = ra_ff;
            uf_wrank = rkb_ff;
         end else begin
            uf_waddr = ra_ff;
            uf_wpar  = rb_ff;
            uf_wrank = rka_ff;
         end
      end else if (cmd.join_bump) begin
         uf_we    = (rka_ff == rkb_ff) && (rkb_ff < RANK_MAX);
         uf_waddr = rb_ff;
         uf_wpar  = rb_ff;
         uf_wrank = rkb_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (uf_we) begin
         par_mem[uf_waddr]  <= uf_wpar;
         rank_mem[uf_waddr] <= uf_wrank;
      end
      if (cmd.uf_read) begin
         par_q_ff  <= par_mem[cur_ff];
         rank_q_ff <= rank_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uf_valid_ff <= '0;
         vq_ff       <= 1'b0;
      end else begin
         if (cmd.init) uf_valid_ff <= '0;
         else if (uf_we) uf_valid_ff[uf_waddr] <= 1'b1;
         if (cmd.uf_read) vq_ff <= uf_valid_ff[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find_start) begin
         cur_ff  <= cmd.sel_b ? VW'(bt_ff) : VW'(bf_ff);
         orig_ff <= cmd.sel_b ? VW'(bt_ff) : VW'(bf_ff);
      end else if (cmd.find_step) begin
         if (uf_par == cur_ff) begin
            root_ff      <= cur_ff;
            root_rank_ff <= uf_rank;
         end else begin
            cur_ff <= uf_par;
         end
      end else if (cmd.comp_start) begin
         cur_ff <= orig_ff;
      end else if (cmd.comp_step) begin
         cur_ff <= uf_par;
      end
      if (cmd.save_root) begin
         if (cmd.sel_b) begin
            rb_ff  <= root_ff;
            rkb_ff <= root_rank_ff;
         end else begin
            ra_ff  <= root_ff;
            rka_ff <= root_rank_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_edge || cmd.emit_summary) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_edge) begin
         rsp.tree_from        <= bf_ff;
         rsp.tree_to          <= bt_ff;
         rsp.tree_edge_weight <= bw_ff;
         rsp.is_summary       <= 1'b0;
         rsp.graph_weight     <= '0;
         rsp.spanning_weight  <= '0;
         rsp.saved_weight     <= '0;
         rsp.last_result      <= 1'b0;
      end else if (cmd.emit_summary) begin
         rsp.tree_from        <= '0;
         rsp.tree_to          <= '0;
         rsp.tree_edge_weight <= '0;
         rsp.is_summary       <= 1'b1;
         rsp.graph_weight     <= total_ff;
         rsp.spanning_weight  <= tree_ff;
         rsp.saved_weight     <= total_ff - tree_ff;
         rsp.last_result      <= 1'b1;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   always_comb begin
      sts.tree_full  = (vc_eff <= VC_W'(1)) || (count_ff == vc_eff - 1'b1);
      sts.scan_done  = (rd_idx_ff == fill_ff) && !eval_ff;
      sts.best_found = best_ff;
      sts.at_root    = (uf_par == cur_ff);
      sts.comp_done  = (cur_ff == root_ff);
      sts.same_root  = (ra_ff == rb_ff);
      sts.out_free   = !rsp_valid_ff || rsp.ready;
   end

   `MST_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_MAX, "edge fill beyond store depth")
   `MST_ASSERT(a_tree_bound, clock, reset, count_ff < VC_MAX, "tree edge count reached vertex count")
   `MST_ASSERT(a_emit_distinct, clock, reset, cmd.emit_edge |-> $past(ra_ff != rb_ff), "tree edge joins one set")
   `MST_ASSERT_ALWAYS(a_reset_fill, clock, $past(reset) |-> fill_ff == '0, "fill not cleared by reset")
endmodule
`default_nettype wire

// ----- hdl/mst_controller.sv -----
// Controller state machine: load, ordered scan, union-find walks and result sequencing
`timescale 1ns / 1ps
`default_nettype none
module mst_controller import mst_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_last,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT     = 4'd1;
   localparam logic [3:0] S_SCAN_BEG = 4'd2;
   localparam logic [3:0] S_SCAN     = 4'd3;
   localparam logic [3:0] S_PICK     = 4'd4;
   localparam logic [3:0] S_FIND_BEG = 4'd5;
   localparam logic [3:0] S_FIND_RD  = 4'd6;
   localparam logic [3:0] S_FIND_CHK = 4'd7;
   localparam logic [3:0] S_COMP_BEG = 4'd8;
   localparam logic [3:0] S_COMP_RD  = 4'd9;
   localparam logic [3:0] S_COMP_WR  = 4'd10;
   localparam logic [3:0] S_JOIN     = 4'd11;
   localparam logic [3:0] S_BUMP     = 4'd12;
   localparam logic [3:0] S_EMIT     = 4'd13;
   localparam logic [3:0] S_SUM      = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       side_ff, side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      side_in   = side_ff;
      cmd       = '0;
      cmd.sel_b = side_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_SCAN_BEG;
         end
         S_SCAN_BEG: begin
            if (sts.tree_full) begin
               state_in = S_SUM;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_PICK;
         end
         S_PICK: begin
            if (!sts.best_found) begin
               state_in = S_SUM;
            end else begin
               cmd.take_best = 1'b1;
               side_in       = 1'b0;
               state_in      = S_FIND_BEG;
            end
         end
         S_FIND_BEG: begin
            cmd.find_start = 1'b1;
            state_in       = S_FIND_RD;
         end
         S_FIND_RD: begin
            cmd.uf_read = 1'b1;
            state_in    = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            cmd.find_step = 1'b1;
            state_in      = sts.at_root ? S_COMP_BEG : S_FIND_RD;
         end
         S_COMP_BEG: begin
            cmd.comp_start = 1'b1;
            state_in       = S_COMP_RD;
         end
         S_COMP_RD: begin
            if (sts.comp_done) begin
               cmd.save_root = 1'b1;
               if (!side_ff) begin
                  side_in  = 1'b1;
                  state_in = S_FIND_BEG;
               end else begin
                  state_in = S_JOIN;
               end
            end else begin
               cmd.uf_read = 1'b1;
               state_in    = S_COMP_WR;
            end
         end
         S_COMP_WR: begin
            cmd.comp_step = 1'b1;
            state_in      = S_COMP_RD;
         end
         S_JOIN: begin
            if (sts.same_root) begin
               state_in = S_SCAN_BEG;
            end else begin
               cmd.join_write = 1'b1;
               state_in       = S_BUMP;
            end
         end
         S_BUMP: begin
            cmd.join_bump = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_edge = 1'b1;
               state_in      = S_SCAN_BEG;
            end
         end
         S_SUM: begin
            if (sts.out_free) begin
               cmd.emit_summary = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- sim/minimum_spanning_tree_engine_test.sv -----
// Self-checking testbench for the Kruskal spanning tree engine
`timescale 1ns / 1ps
`default_nettype none
module minimum_spanning_tree_engine_test;
   import mst_pkg::*;

   typedef struct packed {
      logic [VID_W-1:0] from_id;
      logic [VID_W-1:0] to_id;
      logic [WGT_W-1:0] weight;
      logic             last;
   } edge_item_t;

   typedef struct packed {
      logic [VID_W-1:0] from_id;
      logic [VID_W-1:0] to_id;
      logic [WGT_W-1:0] weight;
      logic             summary;
      logic [ACC_W-1:0] graph_w;
      logic [ACC_W-1:0] span_w;
      logic [ACC_W-1:0] saved_w;
      logic             last;
   } tree_item_t;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mst_req_if req ();
   mst_rsp_if rsp ();
   mst_csr_if csr ();

   minimum_spanning_tree_engine u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   edge_item_t       pending_edges[$];
   tree_item_t       expected_tree[$];
   edge_item_t       graph_edges[$];
   logic [VC_W-1:0]  vertex_count_q;
   logic [ACC_W-1:0] graph_total = '0;
   int               error_count = 0;
   int               edges_sent = 0;
   int               tree_items_seen = 0;
   int               graphs_done = 0;
   int               cycle_count = 0;
   int               req_gap = 0;
   int               rsp_stall = 0;
   bit               quiet = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Kruskal on the accepted graph; appends tree edges and the summary
   task automatic predict_tree();
      int               order[$];
      int               n;
      int               vc;
      int               accepted;
      int               j;
      int               cur;
      int               ra;
      int               rb;
      int               x;
      int               nx;
      logic [5:0]       parent[64];
      logic [2:0]       rank_of[64];
      logic [ACC_W-1:0] tree_sum;
      tree_item_t       t;
      n = graph_edges.size() > MAX_EDGES_DEF ? MAX_EDGES_DEF : graph_edges.size();
      for (int i = 0; i < n; i++) begin
         j = order.size();
         order = {order, i};
         while (j > 0 && graph_edges[order[j-1]].weight > graph_edges[i].weight) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int i = 0; i < 64; i++) begin
         parent[i] = 6'(i);
         rank_of[i] = '0;
      end
      vc = vertex_count_q > 64 ? 64 : int'(vertex_count_q);
      accepted = 0;
      tree_sum = '0;
      for (int i = 0; i < n && vc > 1 && accepted < vc - 1; i++) begin
         cur = order[i];
         if (int'(graph_edges[cur].from_id) >= vc || int'(graph_edges[cur].to_id) >= vc)
            continue;
         ra = int'(graph_edges[cur].from_id);
         while (int'(parent[ra]) != ra) ra = int'(parent[ra]);
         x = int'(graph_edges[cur].from_id);
         while (x != ra) begin nx = int'(parent[x]); parent[x] = 6'(ra); x = nx; end
         rb = int'(graph_edges[cur].to_id);
         while (int'(parent[rb]) != rb) rb = int'(parent[rb]);
         x = int'(graph_edges[cur].to_id);
         while (x != rb) begin nx = int'(parent[x]); parent[x] = 6'(rb); x = nx; end
         if (ra != rb) begin
            if (rank_of[ra] > rank_of[rb]) begin
               parent[rb] = 6'(ra);
            end else begin
               parent[ra] = 6'(rb);
               if (rank_of[ra] == rank_of[rb] && rank_of[rb] < RANK_MAX) rank_of[rb]++;
            end
            tree_sum = tree_sum + ACC_W'(graph_edges[cur].weight);
            accepted++;
            t = '0;
            t.from_id = graph_edges[cur].from_id;
            t.to_id = graph_edges[cur].to_id;
            t.weight = graph_edges[cur].weight;
            expected_tree = {expected_tree, t};
         end
      end
      t = '0;
      t.summary = 1'b1;
      t.graph_w = graph_total;
      t.span_w = tree_sum;
      t.saved_w = graph_total - tree_sum;
      t.last = 1'b1;
      expected_tree = {expected_tree, t};
      graph_edges.delete();
      graph_total = '0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.edge_from <= '0;
         req.edge_to <= '0;
         req.edge_weight <= '0;
         req.last_edge <= 1'b0;
         req_gap <= 0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            graph_edges = {graph_edges, pending_edges[0]};
            graph_total = graph_total + ACC_W'(pending_edges[0].weight);
            edges_sent++;
            if (pending_edges[0].last) predict_tree();
            void'(pending_edges.pop_front());
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(1, 12);
            req.valid <= 1'b0;
         end else if (pending_edges.size() > 0) begin
            req.valid <= 1'b1;
            req.edge_from <= pending_edges[0].from_id;
            req.edge_to <= pending_edges[0].to_id;
            req.edge_weight <= pending_edges[0].weight;
            req.last_edge <= pending_edges[0].last;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tree_item_t w;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            tree_items_seen++;
            if (expected_tree.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               w = expected_tree.pop_front();
               if (rsp.tree_from !== w.from_id)
                  report_mismatch("tree_from", 32'(rsp.tree_from), 32'(w.from_id));
               if (rsp.tree_to !== w.to_id)
                  report_mismatch("tree_to", 32'(rsp.tree_to), 32'(w.to_id));
               if (rsp.tree_edge_weight !== w.weight)
                  report_mismatch("tree_edge_weight", 32'(rsp.tree_edge_weight), 32'(w.weight));
               if (rsp.is_summary !== w.summary)
                  report_mismatch("is_summary", 32'(rsp.is_summary), 32'(w.summary));
               if (rsp.graph_weight !== w.graph_w)
                  report_mismatch("graph_weight", 32'(rsp.graph_weight), 32'(w.graph_w));
               if (rsp.spanning_weight !== w.span_w)
                  report_mismatch("spanning_weight", 32'(rsp.spanning_weight), 32'(w.span_w));
               if (rsp.saved_weight !== w.saved_w)
                  report_mismatch("saved_weight", 32'(rsp.saved_weight), 32'(w.saved_w));
               if (rsp.last_result !== w.last)
                  report_mismatch("last_result", 32'(rsp.last_result), 32'(w.last));
               if (w.summary) graphs_done++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= $urandom_range(1, 12);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_vertex_count(input logic [VC_W-1:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.vertex_count <= value;
      do @(posedge clock); while (!csr.ready);
      vertex_count_q = value;
      csr.valid <= 1'b0;
   endtask

   task automatic add_edge(input int f, input int t, input int w, input bit last);
      edge_item_t e;
      e.from_id = VID_W'(f);
      e.to_id = VID_W'(t);
      e.weight = WGT_W'(w);
      e.last = last;
      pending_edges = {pending_edges, e};
   endtask

   task automatic drain_graph();
      while (pending_edges.size() > 0 || req.valid || expected_tree.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_graph(input int vmax, input int n_edges, input bit wide);
      int hi;
      for (int i = 0; i < n_edges; i++) begin
         hi = wide ? 65535 : $urandom_range(0, 3) == 0 ? 65535 : 15;
         if ($urandom_range(0, 9) == 0)
            add_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, hi),
                     i == n_edges - 1);
         else
            add_edge($urandom_range(0, vmax), $urandom_range(0, vmax),
                     $urandom_range(0, hi), i == n_edges - 1);
      end
   endtask

   initial begin
      int nv;
      csr.valid = 1'b0;
      csr.vertex_count = '0;
      vertex_count_q = VC_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default count: extremes, self-loop, ties
      add_edge(0, 63, 16'hFFFF, 0);
      add_edge(63, 0, 0, 0);
      add_edge(5, 5, 3, 0);
      add_edge(1, 2, 7, 0);
      add_edge(2, 3, 7, 0);
      add_edge(1, 3, 7, 0);
      add_edge(42, 21, 16'hAAAA, 0);
      add_edge(21, 42, 16'h5555, 1);
      drain_graph();
      write_vertex_count(7'd4);
      add_edge(0, 1, 9, 0);
      add_edge(3, 4, 1, 0);
      add_edge(1, 2, 9, 0);
      add_edge(2, 3, 9, 0);
      add_edge(0, 3, 2, 1);
      drain_graph();
      write_vertex_count(7'd1);
      add_edge(0, 0, 5, 0);
      add_edge(0, 1, 6, 1);
      drain_graph();
      write_vertex_count(7'd0);
      add_edge(0, 1, 8, 1);
      drain_graph();
      write_vertex_count(7'd127);
      add_edge(62, 63, 16'hFFFF, 0);
      add_edge(10, 20, 30, 1);
      drain_graph();

      for (int g = 0; g < 12; g++) begin
         nv = $urandom_range(0, 5) == 0 ? $urandom_range(65, 127) : $urandom_range(2, 64);
         write_vertex_count(VC_W'(nv));
         if (g >= 9) quiet = 1'b1;
         random_graph(nv > 64 ? 63 : nv - 1, $urandom_range(3, 14), g[0]);
         drain_graph();
      end
      write_vertex_count(7'd2);
      random_graph(3, 6, 1'b1);
      drain_graph();

      $display("sent %0d edges in %0d graphs, checked %0d results",
               edges_sent, graphs_done, tree_items_seen);
      $display("vertex counts 0 to 127, self-loops, ties, forests and stray ids covered");
      if (error_count == 0 && expected_tree.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
